// ===== rtl/cubemap_face_texel_select_macros.svh =====
// assertion macros for the cube face texel select block
// used by the top level only, needs clk and rst in scope
`ifndef CUBEMAP_FACE_TEXEL_SELECT_MACROS_SVH
`define CUBEMAP_FACE_TEXEL_SELECT_MACROS_SVH

// property that must hold in the same cycle
`define CFTS_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CFTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cfts_pkg.sv =====
// shared types, constants and texel mapping for the cube face texel select block
// no dependencies
package cfts_pkg;

  localparam int DIR_W      = 16;
  localparam int MAG_W      = DIR_W;
  localparam int CFG_W      = 13;
  localparam int MAX_FACE   = 4096;
  localparam int MIN_FACE   = 2;
  localparam int RESET_FACE = 512;
  localparam int H_W        = $clog2(MAX_FACE / 2 + 1);
  localparam int Q_W        = H_W;
  localparam int NUM_W      = MAG_W + H_W + 2;
  localparam int TEX_W      = 12;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = Q_W / DIV_STEPS;

  localparam logic [2:0] FACE_RIGHT  = 3'd0;
  localparam logic [2:0] FACE_LEFT   = 3'd1;
  localparam logic [2:0] FACE_TOP    = 3'd2;
  localparam logic [2:0] FACE_BOTTOM = 3'd3;
  localparam logic [2:0] FACE_FRONT  = 3'd4;
  localparam logic [2:0] FACE_BACK   = 3'd5;

  typedef struct packed {
    logic [2:0]     face;
    logic [H_W-1:0] h;
    logic           neg_u;
    logic           neg_v;
    logic           sat_u;
    logic           sat_v;
    logic           mir_u;
    logic           mir_v;
    logic           zero;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0] r;
    logic [NUM_W-1:0] d;
    logic [Q_W-1:0]   q;
  } div_lane_t;

  // place a rounded minor magnitude on the face, eff = sign xor mirror
  function automatic logic [TEX_W-1:0] map_texel(input logic [Q_W-1:0] q,
                                                 input logic eff,
                                                 input logic [H_W-1:0] h);
    logic [H_W-1:0] qc;
    logic [H_W:0]   sum;
    qc  = (q > h - 1'b1) ? h - 1'b1 : q;
    sum = eff ? {1'b0, h} - {1'b0, q} : {1'b0, h} + {1'b0, qc};
    return TEX_W'(sum);
  endfunction

endpackage

// ===== rtl/cfts_classify.sv =====
// first stage: magnitudes, major axis, face and minor component selection
// depends on cfts_pkg
module cfts_classify import cfts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic signed [DIR_W-1:0] dir_x,
  input  logic signed [DIR_W-1:0] dir_y,
  input  logic signed [DIR_W-1:0] dir_z,
  input  logic [H_W-1:0]          h,
  output logic                    vld,
  output side_t                   side,
  output logic [MAG_W-1:0]        mag_u,
  output logic [MAG_W-1:0]        mag_v,
  output logic [MAG_W-1:0]        mag_m
);

  logic [MAG_W-1:0] ax, ay, az;
  logic             x_maj, y_maj, z_pos, is_zero;
  side_t            side_next;
  logic [MAG_W-1:0] mu_next, mv_next, mm_next;

  assign ax = dir_x[DIR_W-1] ? MAG_W'(-dir_x) : MAG_W'(dir_x);
  assign ay = dir_y[DIR_W-1] ? MAG_W'(-dir_y) : MAG_W'(dir_y);
  assign az = dir_z[DIR_W-1] ? MAG_W'(-dir_z) : MAG_W'(dir_z);

  assign x_maj   = (ax > ay) && (ax > az);
  assign y_maj   = !x_maj && (ay > ax) && (ay > az);
  assign z_pos   = !dir_z[DIR_W-1] && (dir_z != '0);
  assign is_zero = (ax == '0) && (ay == '0) && (az == '0);

  always_comb begin
    side_next   = '0;
    side_next.h = h;
    if (x_maj) begin
      mm_next         = ax;
      mu_next         = az;
      mv_next         = ay;
      side_next.neg_u = dir_z[DIR_W-1];
      side_next.neg_v = dir_y[DIR_W-1];
      side_next.mir_u = !dir_x[DIR_W-1];
      side_next.face  = dir_x[DIR_W-1] ? FACE_LEFT : FACE_RIGHT;
    end else if (y_maj) begin
      mm_next         = ay;
      mu_next         = ax;
      mv_next         = az;
      side_next.neg_u = dir_x[DIR_W-1];
      side_next.neg_v = dir_z[DIR_W-1];
      side_next.mir_v = !dir_y[DIR_W-1];
      side_next.face  = dir_y[DIR_W-1] ? FACE_BOTTOM : FACE_TOP;
    end else begin
      mm_next         = az;
      mu_next         = ax;
      mv_next         = ay;
      side_next.neg_u = dir_x[DIR_W-1];
      side_next.neg_v = dir_y[DIR_W-1];
      side_next.mir_u = !z_pos;
      side_next.face  = z_pos ? FACE_FRONT : FACE_BACK;
    end
    // minor not below major rounds to at least half, which clips the same
    side_next.sat_u = mu_next >= mm_next;
    side_next.sat_v = mv_next >= mm_next;
    side_next.zero  = is_zero;
    if (is_zero) begin
      side_next.face = FACE_FRONT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side  <= side_next;
      mag_u <= mu_next;
      mag_v <= mv_next;
      mag_m <= mm_next;
    end
  end

endmodule

// ===== rtl/cfts_div_stage.sv =====
// one divider stage: DIV_STEPS (3) restoring quotient bits for both minor lanes
// depends on cfts_pkg
module cfts_div_stage import cfts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      vld_in,
  input  side_t     side_in,
  input  div_lane_t lane_u_in,
  input  div_lane_t lane_v_in,
  output logic      vld,
  output side_t     side,
  output div_lane_t lane_u,
  output div_lane_t lane_v
);

  div_lane_t u_next, v_next;

  function automatic div_lane_t div_steps(input div_lane_t l);
    div_lane_t t;
    t = l;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t.d = t.d >> 1;
      if (t.r >= t.d) begin
        t.r = t.r - t.d;
        t.q = {t.q[Q_W-2:0], 1'b1};
      end else begin
        t.q = {t.q[Q_W-2:0], 1'b0};
      end
    end
    return t;
  endfunction

  assign u_next = div_steps(lane_u_in);
  assign v_next = div_steps(lane_v_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side   <= side_in;
      lane_u <= u_next;
      lane_v <= v_next;
    end
  end

endmodule

// ===== rtl/cubemap_face_texel_select.sv =====
// Cube face and texel selection: one direction per request in, one face/texel
// result out. Takes a new request every cycle while the output is not stalled. The
// request is classified at the accepting edge, then come a multiply stage and a
// 12-bit rounding divider that resolves 3 quotient bits per stage over 4 stages,
// then the output register.
// The whole pipeline holds when the result is not taken. face_size is clamped
// to 2..4096 at write and should be written only while no request is in flight.
`include "cubemap_face_texel_select_macros.svh"
module cubemap_face_texel_select import cfts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [DIR_W-1:0] dir_x,
  input  logic signed [DIR_W-1:0] dir_y,
  input  logic signed [DIR_W-1:0] dir_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              face,
  output logic [TEX_W-1:0]        texel_u,
  output logic [TEX_W-1:0]        texel_v,
  output logic                    zero_dir
);

  logic             adv;
  logic [H_W-1:0]   h_cfg;
  logic [CFG_W-1:0] fs_clamped;

  logic             c_vld;
  side_t            c_side;
  logic [MAG_W-1:0] c_mu, c_mv, c_mm;

  logic      m_vld;
  side_t     m_side;
  div_lane_t m_lu, m_lv;

  logic      d_vld  [DIV_STAGES+1];
  side_t     d_side [DIV_STAGES+1];
  div_lane_t d_lu   [DIV_STAGES+1];
  div_lane_t d_lv   [DIV_STAGES+1];

  side_t          f_side;
  logic [Q_W-1:0] qu, qv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // face size register keeps half the clamped edge
  always_comb begin
    fs_clamped = cfg_data;
    if (cfg_data < CFG_W'(MIN_FACE)) begin
      fs_clamped = CFG_W'(MIN_FACE);
    end else if (cfg_data > CFG_W'(MAX_FACE)) begin
      fs_clamped = CFG_W'(MAX_FACE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_cfg <= H_W'(RESET_FACE / 2);
    end else if (cfg_we) begin
      h_cfg <= H_W'(fs_clamped >> 1);
    end
  end

  cfts_classify u_classify (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z),
    .h        (h_cfg),
    .vld      (c_vld),
    .side     (c_side),
    .mag_u    (c_mu),
    .mag_v    (c_mv),
    .mag_m    (c_mm)
  );

  // numerator 2*|c|*h + m, divisor 2*m pre-shifted by the quotient width
  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (adv) begin
      m_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_side <= c_side;
      m_lu.r <= NUM_W'({(MAG_W+H_W)'(c_mu) * (MAG_W+H_W)'(c_side.h), 1'b0}) + NUM_W'(c_mm);
      m_lv.r <= NUM_W'({(MAG_W+H_W)'(c_mv) * (MAG_W+H_W)'(c_side.h), 1'b0}) + NUM_W'(c_mm);
      m_lu.d <= NUM_W'({c_mm, 1'b0}) << Q_W;
      m_lv.d <= NUM_W'({c_mm, 1'b0}) << Q_W;
      m_lu.q <= '0;
      m_lv.q <= '0;
    end
  end

  assign d_vld[0]  = m_vld;
  assign d_side[0] = m_side;
  assign d_lu[0]   = m_lu;
  assign d_lv[0]   = m_lv;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    cfts_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .vld_in    (d_vld[s]),
      .side_in   (d_side[s]),
      .lane_u_in (d_lu[s]),
      .lane_v_in (d_lv[s]),
      .vld       (d_vld[s+1]),
      .side      (d_side[s+1]),
      .lane_u    (d_lu[s+1]),
      .lane_v    (d_lv[s+1])
    );
  end

  assign f_side = d_side[DIV_STAGES];
  assign qu     = f_side.sat_u ? f_side.h : d_lu[DIV_STAGES].q;
  assign qv     = f_side.sat_v ? f_side.h : d_lv[DIV_STAGES].q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      face     <= f_side.face;
      zero_dir <= f_side.zero;
      if (f_side.zero) begin
        texel_u <= TEX_W'(f_side.h);
        texel_v <= TEX_W'(f_side.h);
      end else begin
        texel_u <= map_texel(qu, f_side.neg_u ^ f_side.mir_u, f_side.h);
        texel_v <= map_texel(qv, f_side.neg_v ^ f_side.mir_v, f_side.h);
      end
    end
  end

  `CFTS_ASSERT_NOW(a_zero_front,
    !(out_valid && zero_dir) || (face == FACE_FRONT && texel_u == texel_v),
    "zero direction must give front face at center")
  `CFTS_ASSERT_NOW(a_texel_range,
    !out_valid || ((texel_u < ({1'b0, h_cfg} << 1)) && (texel_v < ({1'b0, h_cfg} << 1))),
    "texel outside face")
  `CFTS_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
    out_valid && !in_ready == !out_ready, "pipeline moved while result held")

endmodule

// ===== verif/cubemap_face_texel_select_tb.sv =====
// testbench for cubemap_face_texel_select: random and directed directions with face size changes
// depends on cfts_pkg and the cubemap_face_texel_select rtl
`timescale 1ns / 1ps
module cubemap_face_texel_select_tb import cfts_pkg::*; ;

  typedef struct {
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic signed [DIR_W-1:0] z;
  } dir_req_t;

  typedef struct {
    logic [2:0]       face;
    logic [TEX_W-1:0] u;
    logic [TEX_W-1:0] v;
    logic             zero;
  } texel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DIR_W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] face;
  logic [TEX_W-1:0] texel_u, texel_v;
  logic zero_dir;

  dir_req_t pending_dirs[$];
  texel_t   expected_texels[$];
  int unsigned cur_face_size = RESET_FACE;
  int errors = 0;
  int checked = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit hold_send = 1'b0;
  int stall_phase = 0;
  int sizes_used = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cubemap_face_texel_select dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .face(face), .texel_u(texel_u), .texel_v(texel_v), .zero_dir(zero_dir)
  );

  // rounded c*h/m, half away from zero; zero major saturates by sign
  function automatic longint scaled_minor(longint c, longint m, longint h);
    longint q;
    longint ac;
    ac = c < 0 ? -c : c;
    if (m == 0) q = h;
    else q = (2 * ac * h + m) / (2 * m);
    return c < 0 ? -q : q;
  endfunction

  function automatic longint clamp(longint val, longint lo, longint hi);
    return val < lo ? lo : (val > hi ? hi : val);
  endfunction

  function automatic texel_t predict_texel(dir_req_t d, int unsigned fsize);
    texel_t t;
    longint x, y, z, ax, ay, az, h, u, v, s1, s2;
    x = d.x; y = d.y; z = d.z;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    if (fsize < MIN_FACE) fsize = MIN_FACE;
    if (fsize > MAX_FACE) fsize = MAX_FACE;
    h = fsize / 2;
    t.zero = 1'b0;
    if (ax == 0 && ay == 0 && az == 0) begin
      t.zero = 1'b1;
      t.face = FACE_FRONT;
      u = h;
      v = h;
    end else if (ax > ay && ax > az) begin
      s1 = scaled_minor(y, ax, h);
      s2 = scaled_minor(z, ax, h);
      v = clamp(s1, -h, h - 1) + h;
      if (x > 0) begin
        t.face = FACE_RIGHT;
        u = h - clamp(s2, -h + 1, h);
      end else begin
        t.face = FACE_LEFT;
        u = clamp(s2, -h, h - 1) + h;
      end
    end else if (ay > ax && ay > az) begin
      s1 = scaled_minor(x, ay, h);
      s2 = scaled_minor(z, ay, h);
      u = clamp(s1, -h, h - 1) + h;
      if (y > 0) begin
        t.face = FACE_TOP;
        v = h - clamp(s2, -h + 1, h);
      end else begin
        t.face = FACE_BOTTOM;
        v = clamp(s2, -h, h - 1) + h;
      end
    end else begin
      s1 = scaled_minor(x, az, h);
      s2 = scaled_minor(y, az, h);
      v = clamp(s2, -h, h - 1) + h;
      if (z > 0) begin
        t.face = FACE_FRONT;
        u = clamp(s1, -h, h - 1) + h;
      end else begin
        t.face = FACE_BACK;
        u = h - clamp(s1, -h + 1, h);
      end
    end
    t.u = TEX_W'(u);
    t.v = TEX_W'(v);
    return t;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("error: result %0d field %s got %0d expected %0d", checked, what, got, want);
    errors++;
  endtask

  task automatic add_dir(int x, int y, int z);
    dir_req_t d;
    d.x = DIR_W'(x);
    d.y = DIR_W'(y);
    d.z = DIR_W'(z);
    pending_dirs.push_back(d);
  endtask

  function automatic int rand_dir();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(0, 1) ? 32767 : -32768;
    if (sel == 1) return int'($urandom_range(0, 6)) - 3;
    if (sel < 5) return int'($urandom_range(0, 600)) - 300;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic add_random_dir();
    int x, y, z, m;
    x = rand_dir();
    y = rand_dir();
    z = rand_dir();
    case ($urandom_range(0, 7))
      0: begin
        // ties between axis magnitudes
        m = $urandom_range(1, 32767);
        x = $urandom_range(0, 1) ? m : -m;
        y = $urandom_range(0, 1) ? m : -m;
        if ($urandom_range(0, 1)) z = 0;
      end
      1: z = $urandom_range(0, 1) ? x : -x;
      default: ;
    endcase
    add_dir(x, y, z);
  endtask

  // driver: bursts with random gaps; the request on the bus stays at the queue head
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_texels.push_back(predict_texel(pending_dirs[0], cur_face_size));
        void'(pending_dirs.pop_front());
      end
      if ((!in_valid || in_ready) && pending_dirs.size() > 0 && !hold_send) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else begin
          dir_req_t nd;
          nd = pending_dirs[0];
          in_valid <= 1'b1;
          dir_x <= nd.x;
          dir_y <= nd.y;
          dir_z <= nd.z;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      stall_phase <= (stall_phase + 1) % 97;
      out_ready <= (stall_phase < 30) ? 1'b1 :
                   (stall_phase < 60) ? ($urandom_range(0, 3) != 0) :
                   ($urandom_range(0, 1) == 1);
      if (out_valid && out_ready) begin
        if (expected_texels.size() == 0) begin
          $display("error: result with no request outstanding");
          errors++;
        end else begin
          texel_t e;
          e = expected_texels.pop_front();
          if (face !== e.face) report_mismatch("face", face, e.face);
          if (texel_u !== e.u) report_mismatch("texel_u", texel_u, e.u);
          if (texel_v !== e.v) report_mismatch("texel_v", texel_v, e.v);
          if (zero_dir !== e.zero) report_mismatch("zero_dir", zero_dir, e.zero);
        end
        checked++;
      end
    end
    if (cycles > 400000) begin
      $display("cubemap_face_texel_select: mismatch");
      $finish;
    end
  end

  task automatic drain();
    wait (pending_dirs.size() == 0 && !in_valid);
    wait (expected_texels.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_face_size(int unsigned fs);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= CFG_W'(fs);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_face_size = fs;
    sizes_used++;
  endtask

  initial begin
    int unsigned sizes[8];
    sizes = '{512, 2, 4096, 3, 0, 8191, 17, 1000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // directed corners at reset face size
    add_dir(0, 0, 0);
    add_dir(32767, 0, 0);
    add_dir(-32768, 0, 0);
    add_dir(0, 32767, 0);
    add_dir(0, -32768, 0);
    add_dir(0, 0, 32767);
    add_dir(0, 0, -32768);
    add_dir(100, 100, 0);
    add_dir(-100, 100, 0);
    add_dir(100, -100, 0);
    add_dir(-32768, -32768, 0);
    add_dir(5, 5, 5);
    add_dir(-5, 5, -5);
    add_dir(32767, -32768, 32767);
    add_dir(1, 0, 0);
    add_dir(-1, 1, 0);
    add_dir(3, 2, -2);
    add_dir(-32767, 32767, -32768);
    add_dir(2, 1, 1);
    add_dir(-1, -1, -1);
    drain();
    foreach (sizes[i]) begin
      set_face_size(sizes[i]);
      for (int k = 0; k < 225; k++) begin
        add_random_dir();
        if (i == 3 && k == 100) begin
          // pause sending until the pipe is empty
          wait (pending_dirs.size() == 0 && !in_valid);
          hold_send = 1'b1;
          wait (expected_texels.size() == 0);
          hold_send = 1'b0;
        end
      end
      add_dir(0, 0, 0);
      drain();
    end
    $display("covered %0d results over %0d face sizes incl. clamped extremes", checked,
             sizes_used + 1);
    if (errors == 0) begin
      $display("cubemap_face_texel_select: match");
    end else begin
      $display("cubemap_face_texel_select: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cfts_pkg.sv
rtl/cfts_classify.sv
rtl/cfts_div_stage.sv
rtl/cubemap_face_texel_select.sv
verif/cubemap_face_texel_select_tb.sv
